FILE: rtl/pngse_pkg.sv
package pngse_pkg;

   localparam int DEFAULT_MAX_SIDE = 8192;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] CRC_POLY = 32'hedb88320;
   localparam logic [31:0] CRC_INIT = 32'hffffffff;
   localparam logic [16:0] ADLER_MOD = 17'd65521;
   localparam logic [16:0] BLOCK_MAX = 17'd65535;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
      logic       filter;
      logic       last;
   } item_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] be_byte(input logic [31:0] word, input logic [1:0] k);
      logic [7:0] b;
      case (k)
         2'd0: b = word[31:24];
         2'd1: b = word[23:16];
         2'd2: b = word[15:8];
         default: b = word[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [7:0] head_byte(input logic [5:0] idx);
      logic [7:0] b;
      case (idx)
         6'd0: b = 8'h89;
         6'd1: b = 8'h50;
         6'd2: b = 8'h4e;
         6'd3: b = 8'h47;
         6'd4: b = 8'h0d;
         6'd5: b = 8'h0a;
         6'd6: b = 8'h1a;
         6'd7: b = 8'h0a;
         6'd11: b = 8'h0d;
         6'd12: b = 8'h49;
         6'd13: b = 8'h48;
         6'd14: b = 8'h44;
         6'd15: b = 8'h52;
         6'd24: b = 8'h08;
         6'd25: b = 8'h02;
         6'd37: b = 8'h49;
         6'd38: b = 8'h44;
         6'd39: b = 8'h41;
         6'd40: b = 8'h54;
         6'd41: b = 8'h78;
         6'd42: b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] tail_byte(input logic [5:0] idx);
      logic [7:0] b;
      case (idx)
         6'd12: b = 8'h49;
         6'd13: b = 8'h45;
         6'd14: b = 8'h4e;
         6'd15: b = 8'h44;
         6'd16: b = 8'hae;
         6'd17: b = 8'h42;
         6'd18: b = 8'h60;
         6'd19: b = 8'h82;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/png_rgb8_stored_encoder.sv
// The first output byte of a transaction is registered after the accepted byte passes a
// queue slot and the sequencer state. One output byte per cycle goes out unless rsp_ready
// stalls it; a row start adds a filter byte, a stored block boundary a block header, a
// file's first byte the PNG headers and its last byte the trailer; a four-entry queue
// decouples input from output. Reset is synchronous and active high; it returns the
// block to the start of a file with both image dimensions set to one.
module png_rgb8_stored_encoder #(
   parameter int MAX_SIDE = pngse_pkg::DEFAULT_MAX_SIDE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_file_last
);
   import pngse_pkg::*;

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);

   item_type          push_item, pop_item;
   logic              push_valid, push_ready, pop_valid, pop_ready;
   logic [SIDE_W-1:0] width, height;

   pngse_front #(.MAX_SIDE(MAX_SIDE)) u_front (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .push_item(push_item),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .width(width),
      .height(height)
   );

   pngse_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_item(push_item),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .pop_item(pop_item),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready)
   );

   pngse_back #(.MAX_SIDE(MAX_SIDE)) u_back (
      .clock(clock),
      .reset(reset),
      .width(width),
      .height(height),
      .pop_item(pop_item),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last),
      .rsp_file_last(rsp_file_last)
   );

endmodule

FILE: rtl/pngse_front.sv
module pngse_front #(
   parameter int MAX_SIDE = pngse_pkg::DEFAULT_MAX_SIDE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [2:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_data_byte,
   output pngse_pkg::item_type              push_item,
   output logic                             push_valid,
   input  logic                             push_ready,
   output logic [$clog2(MAX_SIDE+1)-1:0]    width,
   output logic [$clog2(MAX_SIDE+1)-1:0]    height
);
   import pngse_pkg::*;

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int COL_W = $clog2(3 * MAX_SIDE);
   localparam int ROW_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam logic REG_WIDTH = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   logic [SIDE_W-1:0] width_ff, width_in, height_ff, height_in, clamped;
   logic [COL_W-1:0]  col_ff, col_in, col_end;
   logic [ROW_W-1:0]  row_ff, row_in, row_end;
   logic              busy_ff, busy_in;
   logic              wr, acc, at_col_end, at_last;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite & ~busy_ff;
   assign csr_prdata = (csr_paddr[2] == REG_HEIGHT) ? 32'(height_ff) : 32'(width_ff);

   always_comb begin
      if (csr_pwdata[13:0] == 14'd0) begin
         clamped = SIDE_W'(1);
      end else if (32'(csr_pwdata[13:0]) > 32'(MAX_SIDE)) begin
         clamped = SIDE_W'(MAX_SIDE);
      end else begin
         clamped = SIDE_W'(csr_pwdata[13:0]);
      end
   end

   assign width_in = (wr && csr_paddr[2] == REG_WIDTH) ? clamped : width_ff;
   assign height_in = (wr && csr_paddr[2] == REG_HEIGHT) ? clamped : height_ff;

   assign col_end = COL_W'(3 * 32'(width_ff) - 1);
   assign row_end = ROW_W'(32'(height_ff) - 1);
   assign at_col_end = (col_ff == col_end);
   assign at_last = at_col_end && (row_ff == row_end);

   assign req_ready = push_ready;
   assign push_valid = req_valid;
   assign acc = req_valid & push_ready;
   assign push_item.data_byte = req_data_byte;
   assign push_item.first = ~busy_ff;
   assign push_item.filter = (col_ff == '0);
   assign push_item.last = at_last;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      busy_in = busy_ff;
      if (acc) begin
         busy_in = ~at_last;
         if (at_col_end) begin
            col_in = '0;
            row_in = at_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= SIDE_W'(1);
         height_ff <= SIDE_W'(1);
         col_ff <= '0;
         row_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         col_ff <= col_in;
         row_ff <= row_in;
         busy_ff <= busy_in;
      end
   end

   assign width = width_ff;
   assign height = height_ff;

endmodule

FILE: rtl/pngse_queue.sv
module pngse_queue (
   input  logic                clock,
   input  logic                reset,
   input  pngse_pkg::item_type push_item,
   input  logic                push_valid,
   output logic                push_ready,
   output pngse_pkg::item_type pop_item,
   output logic                pop_valid,
   input  logic                pop_ready
);
   import pngse_pkg::*;

   item_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               push, pop;

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign push = push_valid & push_ready;
   assign pop = pop_valid & pop_ready;
   assign pop_item = slot_ff[rd_ff];

   assign wr_in = push ? ((wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1)) : wr_ff;
   assign rd_in = pop ? ((rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1)) : rd_ff;
   assign cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: rtl/pngse_back.sv
module pngse_back #(
   parameter int MAX_SIDE = pngse_pkg::DEFAULT_MAX_SIDE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(MAX_SIDE+1)-1:0]    width,
   input  logic [$clog2(MAX_SIDE+1)-1:0]    height,
   input  pngse_pkg::item_type              pop_item,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_run_last,
   output logic                             rsp_file_last
);
   import pngse_pkg::*;

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int RAW_W = $clog2((3 * MAX_SIDE + 1) * MAX_SIDE + 1);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HEAD = 2'd1;
   localparam logic [1:0] PH_RAW = 2'd2;
   localparam logic [1:0] PH_TAIL = 2'd3;

   localparam logic [5:0] HI_IHDR_TYPE = 6'd12;
   localparam logic [5:0] HI_WIDTH = 6'd16;
   localparam logic [5:0] HI_HEIGHT = 6'd20;
   localparam logic [5:0] HI_IHDR_END = 6'd28;
   localparam logic [5:0] HI_IHDR_CRC = 6'd29;
   localparam logic [5:0] HI_IDAT_LEN = 6'd33;
   localparam logic [5:0] HI_IDAT_TYPE = 6'd37;
   localparam logic [5:0] HI_END = 6'd42;
   localparam logic [5:0] BI_END = 6'd4;
   localparam logic [5:0] TI_CRC = 6'd4;
   localparam logic [5:0] TI_ZERO = 6'd8;
   localparam logic [5:0] TI_IEND_TYPE = 6'd12;
   localparam logic [5:0] TI_IEND_CRC = 6'd16;
   localparam logic [5:0] TI_END = 6'd19;

   logic [SIDE_W+1:0]   row_bytes;
   logic [2*SIDE_W+1:0] raw_prod;
   logic [RAW_W-1:0]    raw_ff, rawrem_ff, rawrem_in;
   logic [31:0]         raw32, rawrem32, len_ff;
   logic [16:0]         fold, fold_r;
   logic                fold_wrap;
   logic [15:0]         nblk_ff, blk, blkrem_ff, blkrem_in;

   logic [1:0]  phase_ff, phase_in;
   logic [5:0]  hidx_ff, hidx_in;
   item_type    cur_ff, cur_in;
   logic        filt_ff, filt_in;
   logic [31:0] crc_ff, crc_in, crc_base;
   logic [15:0] low_ff, low_in, high_ff, high_in;
   logic [16:0] low_s, high_s;
   logic [15:0] low_n, high_n;

   logic        adv, fire, use_crc, restart, item_done, eof;
   logic [7:0]  out_b;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_out_byte_ff;
   logic        rsp_run_last_ff, rsp_file_last_ff;

   assign row_bytes = (SIDE_W+2)'({width, 1'b0}) + (SIDE_W+2)'(width) + (SIDE_W+2)'(1);
   assign raw_prod = (2*SIDE_W+2)'(row_bytes) * (2*SIDE_W+2)'(height);

   assign raw32 = 32'(raw_ff);
   assign fold = 17'(raw32[31:16]) + 17'(raw32[15:0]);
   assign fold_wrap = (fold >= BLOCK_MAX);
   assign fold_r = fold_wrap ? fold - BLOCK_MAX : fold;

   always_ff @(posedge clock) begin
      raw_ff <= RAW_W'(raw_prod);
      nblk_ff <= raw32[31:16] + 16'(fold_wrap) + 16'(fold_r != 17'd0);
      len_ff <= raw32 + 32'({nblk_ff, 2'b00}) + 32'(nblk_ff) + 32'd6;
   end

   assign rawrem32 = 32'(rawrem_ff);
   assign blk = (rawrem32 > 32'(BLOCK_MAX)) ? 16'hffff : rawrem32[15:0];

   assign low_s = {1'b0, low_ff} + 17'(out_b);
   assign low_n = (low_s >= ADLER_MOD) ? 16'(low_s - ADLER_MOD) : low_s[15:0];
   assign high_s = {1'b0, high_ff} + {1'b0, low_n};
   assign high_n = (high_s >= ADLER_MOD) ? 16'(high_s - ADLER_MOD) : high_s[15:0];

   assign adv = ~rsp_valid_ff | rsp_ready;
   assign fire = adv && (phase_ff != PH_IDLE);

   always_comb begin
      out_b = 8'h00;
      use_crc = 1'b0;
      restart = 1'b0;
      item_done = 1'b0;
      eof = 1'b0;
      pop_ready = 1'b0;
      phase_in = phase_ff;
      hidx_in = hidx_ff;
      cur_in = cur_ff;
      filt_in = filt_ff;
      rawrem_in = rawrem_ff;
      blkrem_in = blkrem_ff;
      low_in = low_ff;
      high_in = high_ff;
      case (phase_ff)
         PH_HEAD: begin
            if (hidx_ff >= HI_WIDTH && hidx_ff < HI_HEIGHT) begin
               out_b = be_byte(32'(width), 2'(hidx_ff - HI_WIDTH));
            end else if (hidx_ff >= HI_HEIGHT && hidx_ff < HI_HEIGHT + 6'd4) begin
               out_b = be_byte(32'(height), 2'(hidx_ff - HI_HEIGHT));
            end else if (hidx_ff >= HI_IHDR_CRC && hidx_ff < HI_IDAT_LEN) begin
               out_b = be_byte(~crc_ff, 2'(hidx_ff - HI_IHDR_CRC));
            end else if (hidx_ff >= HI_IDAT_LEN && hidx_ff < HI_IDAT_TYPE) begin
               out_b = be_byte(len_ff, 2'(hidx_ff - HI_IDAT_LEN));
            end else begin
               out_b = head_byte(hidx_ff);
            end
            use_crc = (hidx_ff >= HI_IHDR_TYPE && hidx_ff <= HI_IHDR_END) ||
                      (hidx_ff >= HI_IDAT_TYPE);
            restart = (hidx_ff == HI_IHDR_TYPE) || (hidx_ff == HI_IDAT_TYPE);
            if (fire) begin
               if (hidx_ff == HI_END) begin
                  phase_in = PH_RAW;
                  hidx_in = '0;
                  rawrem_in = raw_ff;
                  blkrem_in = '0;
                  low_in = 16'd1;
                  high_in = 16'd0;
               end else begin
                  hidx_in = hidx_ff + 6'd1;
               end
            end
         end
         PH_RAW: begin
            use_crc = 1'b1;
            if (blkrem_ff == '0) begin
               case (hidx_ff[2:0])
                  3'd0: out_b = {7'd0, rawrem32 <= 32'(BLOCK_MAX)};
                  3'd1: out_b = blk[7:0];
                  3'd2: out_b = blk[15:8];
                  3'd3: out_b = ~blk[7:0];
                  default: out_b = ~blk[15:8];
               endcase
               if (fire) begin
                  if (hidx_ff == BI_END) begin
                     hidx_in = '0;
                     blkrem_in = blk;
                  end else begin
                     hidx_in = hidx_ff + 6'd1;
                  end
               end
            end else begin
               out_b = filt_ff ? 8'h00 : cur_ff.data_byte;
               if (fire) begin
                  low_in = low_n;
                  high_in = high_n;
                  blkrem_in = blkrem_ff - 16'd1;
                  rawrem_in = rawrem_ff - RAW_W'(1);
                  if (filt_ff) begin
                     filt_in = 1'b0;
                  end else if (cur_ff.last) begin
                     phase_in = PH_TAIL;
                     hidx_in = '0;
                  end else begin
                     item_done = 1'b1;
                  end
               end
            end
         end
         PH_TAIL: begin
            if (hidx_ff < TI_CRC) begin
               out_b = be_byte({high_ff, low_ff}, hidx_ff[1:0]);
            end else if (hidx_ff < TI_ZERO) begin
               out_b = be_byte(~crc_ff, hidx_ff[1:0]);
            end else begin
               out_b = tail_byte(hidx_ff);
            end
            use_crc = (hidx_ff < TI_CRC) ||
                      (hidx_ff >= TI_IEND_TYPE && hidx_ff < TI_IEND_CRC);
            restart = (hidx_ff == TI_IEND_TYPE);
            if (fire) begin
               if (hidx_ff == TI_END) begin
                  item_done = 1'b1;
                  eof = 1'b1;
               end else begin
                  hidx_in = hidx_ff + 6'd1;
               end
            end
         end
         default: begin
         end
      endcase
      if (phase_ff == PH_IDLE || item_done) begin
         if (pop_valid) begin
            pop_ready = 1'b1;
            cur_in = pop_item;
            filt_in = pop_item.filter;
            phase_in = pop_item.first ? PH_HEAD : PH_RAW;
            hidx_in = '0;
         end else begin
            phase_in = PH_IDLE;
         end
      end
   end

   assign crc_base = restart ? CRC_INIT : crc_ff;
   assign crc_in = (fire && use_crc) ? crc_byte(crc_base, out_b) : crc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hidx_ff <= '0;
         filt_ff <= 1'b0;
         rawrem_ff <= '0;
         blkrem_ff <= '0;
         crc_ff <= CRC_INIT;
         low_ff <= 16'd1;
         high_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         hidx_ff <= hidx_in;
         filt_ff <= filt_in;
         rawrem_ff <= rawrem_in;
         blkrem_ff <= blkrem_in;
         crc_ff <= crc_in;
         low_ff <= low_in;
         high_ff <= high_in;
         if (adv) begin
            rsp_valid_ff <= fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (fire) begin
         rsp_out_byte_ff <= out_b;
         rsp_run_last_ff <= item_done;
         rsp_file_last_ff <= eof;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_run_last = rsp_run_last_ff;
   assign rsp_file_last = rsp_file_last_ff;

`ifndef SYNTHESIS
   a_file_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_file_last_ff |-> rsp_run_last_ff)
      else $error("File end is not the end of a transaction.");
   a_block_within_raw: assert property (@(posedge clock) disable iff (reset)
      32'(blkrem_ff) <= rawrem32)
      else $error("Stored block runs past the image data.");
   a_tail_after_data: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TAIL |-> rawrem_ff == '0)
      else $error("Trailer started before all image data went out.");
   a_tail_marks_end: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_TAIL && hidx_ff == TI_END |=> rsp_valid_ff && rsp_file_last_ff)
      else $error("Final IEND byte is not marked.");
`endif

endmodule
